// File: hw/rtl/binary_heap_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Heap queue assertion macros
// Concurrent assertion shorthands sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition holds at every edge
`define BHPQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BHPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// Heap queue package
// Shared widths, types, request, status and order codes of the heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 7;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [REQ_W-1:0]          req_t;
    typedef logic [STATUS_W-1:0]       status_t;

    // request codes
    localparam req_t REQ_PUSH  = 2'd0;
    localparam req_t REQ_POP   = 2'd1;
    localparam req_t REQ_QUERY = 2'd2;

    // status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // order_mode values
    localparam logic ORDER_MIN = 1'b0;
    localparam logic ORDER_MAX = 1'b1;

endpackage

// File: hw/rtl/bhpq_store.sv
// ----------------------------------------------------------------------------
// Heap entry store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module bhpq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  bhpq_pkg::value_t wdata,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output bhpq_pkg::value_t rdata_a,
    output bhpq_pkg::value_t rdata_b
);

    bhpq_pkg::value_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hw/rtl/bhpq_rank.sv
// ----------------------------------------------------------------------------
// Heap rank comparator
// Shared compare unit: says whether one entry ranks strictly above another.
// ----------------------------------------------------------------------------
module bhpq_rank (
    input  logic             order_mode,
    input  bhpq_pkg::value_t lhs,
    input  bhpq_pkg::value_t rhs,
    output logic             above
);

    // signed compare in the direction of the current order
    always_comb
    begin
        if (order_mode == bhpq_pkg::ORDER_MAX)
        begin
            above = (lhs > rhs);
        end
        else
        begin
            above = (lhs < rhs);
        end
    end

endmodule

// File: hw/rtl/binary_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Array-backed min/max heap of signed 32-bit values with a stream interface.
// ----------------------------------------------------------------------------
// Each input beat is one request (push, pop or query) and returns exactly one
// output beat with the root after the request, the entry count, an empty flag
// and a status. The block takes one request at a time. A query or a refused
// request goes straight to done; a push reads the parent, compares and moves
// it down per level the value climbs, then writes the value; a pop reads the
// last entry, then per level it sinks reads the children, picks the better
// one, compares and moves it up, then writes the moved entry. This order is
// set by the registered reads of the entry store and the single comparator
// that every sift step shares. A finished result waits in the output register
// while the next request is taken; that request holds in its last cycle until
// the previous beat has left. The store is never cleared; only filled entries
// are used. order_mode may be changed only while the queue is idle.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // order_mode
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] top_value, [38:32] entry_count, rest zero
    output logic [2:0]  m_axis_tuser    // [0] is_empty, [2:1] status
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = AW + 2;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_POP_LD  = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_PICK = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]                            state_reg, state_next;
    logic [CW-1:0]                         count_reg, count_next;
    logic [AW-1:0]                         pos_reg, pos_next;
    logic [AW-1:0]                         bidx_reg, bidx_next;
    bhpq_pkg::value_t                      cur_reg, cur_next;
    bhpq_pkg::value_t                      best_reg, best_next;
    bhpq_pkg::value_t                      root_reg, root_next;
    bhpq_pkg::status_t                     status_reg, status_next;
    logic                                  order_mode_reg;
    logic                                  m_valid_reg, m_valid_next;
    bhpq_pkg::value_t                      m_top_reg, m_top_next;
    logic [bhpq_pkg::ENTRY_COUNT_W-1:0]    m_count_reg, m_count_next;
    logic                                  m_empty_reg, m_empty_next;
    bhpq_pkg::status_t                     m_status_reg, m_status_next;

    logic                                  s_fire;
    logic                                  mem_we;
    logic [AW-1:0]                         mem_waddr;
    bhpq_pkg::value_t                      mem_wdata;
    logic [AW-1:0]                         raddr_a;
    logic [AW-1:0]                         raddr_b;
    bhpq_pkg::value_t                      rd_a;
    bhpq_pkg::value_t                      rd_b;
    bhpq_pkg::value_t                      cmp_lhs;
    bhpq_pkg::value_t                      cmp_rhs;
    logic                                  cmp_above;
    logic [CW-1:0]                         count_dec;
    logic [AW-1:0]                         parent_idx;
    logic [KW-1:0]                         kid_idx;
    logic [KW-1:0]                         kid1_idx;
    logic [KW-1:0]                         count_k;

    // entry store and shared comparator
    bhpq_store #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    bhpq_rank u_rank (
        .order_mode (order_mode_reg),
        .lhs        (cmp_lhs),
        .rhs        (cmp_rhs),
        .above      (cmp_above)
    );

    // handshake and index arithmetic
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign count_dec     = count_reg - CW'(1);
    assign parent_idx    = (pos_reg - AW'(1)) >> 1;
    assign kid_idx       = {1'b0, pos_reg, 1'b1};
    assign kid1_idx      = kid_idx + KW'(1);
    assign count_k       = KW'(count_reg);

    // sift sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        bidx_next     = bidx_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_top_next    = m_top_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = cur_reg;
        raddr_a       = count_dec[AW-1:0];
        raddr_b       = kid1_idx[AW-1:0];
        cmp_lhs       = cur_reg;
        cmp_rhs       = rd_a;

        // output beat taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    status_next = bhpq_pkg::ST_DONE;
                    case (s_axis_tuser)
                        bhpq_pkg::REQ_PUSH:
                        begin
                            if (count_reg == CW'(HEAP_DEPTH))
                            begin
                                status_next = bhpq_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                cur_next   = s_axis_tdata;
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        bhpq_pkg::REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bhpq_pkg::ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                // last entry is read this cycle
                                count_next = count_dec;
                                state_next = S_POP_LD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr_a    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                // move the parent down while the new value ranks above it
                mem_we = 1'b1;
                if (cmp_above)
                begin
                    mem_wdata  = rd_a;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_LD:
            begin
                cur_next   = rd_a;
                pos_next   = '0;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (kid_idx >= count_k)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr_a    = kid_idx[AW-1:0];
                    state_next = S_DN_PICK;
                end
            end
            S_DN_PICK:
            begin
                // pick the better child, left on a tie
                cmp_lhs = rd_b;
                cmp_rhs = rd_a;
                if ((kid1_idx < count_k) && cmp_above)
                begin
                    best_next = rd_b;
                    bidx_next = kid1_idx[AW-1:0];
                end
                else
                begin
                    best_next = rd_a;
                    bidx_next = kid_idx[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                // move the child up while it ranks above the sinking value
                cmp_lhs = best_reg;
                cmp_rhs = cur_reg;
                mem_we  = 1'b1;
                if (cmp_above)
                begin
                    mem_wdata  = best_reg;
                    pos_next   = bidx_reg;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_top_next    = (count_reg != '0) ? root_reg : '0;
                    m_count_next  = bhpq_pkg::ENTRY_COUNT_W'(count_reg);
                    m_empty_next  = (count_reg == '0);
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root shadow follows every write to entry zero
    assign root_next = (mem_we && (mem_waddr == '0)) ? mem_wdata : root_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            order_mode_reg <= bhpq_pkg::ORDER_MAX;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                order_mode_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        bidx_reg     <= bidx_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        root_reg     <= root_next;
        status_reg   <= status_next;
        m_top_reg    <= m_top_next;
        m_count_reg  <= m_count_next;
        m_empty_reg  <= m_empty_next;
        m_status_reg <= m_status_next;
    end

    // result beat
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_count_reg, m_top_reg};
    assign m_axis_tuser  = {m_status_reg, m_empty_reg};

`include "binary_heap_priority_queue_top_assert.svh"

    `BHPQ_ASSERT_ALWAYS(a_count_in_range, count_reg <= CW'(HEAP_DEPTH),
        "entry count above heap depth")

    `BHPQ_ASSERT_IMPLY(a_write_in_heap, mem_we,
        ((CW'(mem_waddr) < count_reg) || (mem_waddr == '0)),
        "store write outside the filled part of the heap")

    `BHPQ_ASSERT_NEXT(a_pop_decrements,
        s_fire && (s_axis_tuser == bhpq_pkg::REQ_POP) && (count_reg != '0),
        count_reg == ($past(count_reg) - CW'(1)),
        "accepted pop did not remove one entry")

    `BHPQ_ASSERT_IMPLY(a_full_result_count,
        m_valid_reg && (m_status_reg == bhpq_pkg::ST_FULL),
        m_count_reg == bhpq_pkg::ENTRY_COUNT_W'(HEAP_DEPTH),
        "full status reported with a count below depth")

endmodule
